// ----- src/r2e_pkg.sv -----
`timescale 1ns / 1ps
package r2e_pkg;
	localparam int W = 28;
	localparam int ZW = 24;
	localparam int STEPS_DEF = 16;
	localparam int PRE_SHIFT = 8;
	localparam logic signed [ZW-1:0] PI_FINE = 24'sd3294199;
	localparam logic signed [ZW-1:0] PI_OUT = 24'sd25736;
	localparam logic [15:0] INV_GAIN = 16'd39797;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} lane_t;

	function automatic logic signed [ZW-1:0] atan_fine(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Scale up, fold the left half plane onto the right one.
	function automatic lane_t prep_atan(input logic signed [W-1:0] yv,
			input logic signed [W-1:0] xv);
		lane_t r;
		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;
		xs = xv <<< PRE_SHIFT;
		ys = yv <<< PRE_SHIFT;
		r.zero = (xv == '0) && (yv == '0);
		if (xv[W-1]) begin
			r.x = -xs;
			r.y = -ys;
			r.z = ys[W-1] ? -PI_FINE : PI_FINE;
		end else begin
			r.x = xs;
			r.y = ys;
			r.z = '0;
		end
		return r;
	endfunction

	// Round half up to Q3.13 and clamp to +-pi; a zero input vector gives zero.
	function automatic logic signed [15:0] post_angle(input logic signed [ZW-1:0] z,
			input logic zero);
		logic signed [ZW-1:0] r;
		logic signed [15:0] o;
		r = (z + 24'sd64) >>> 7;
		if (zero) o = '0;
		else if (r > PI_OUT) o = PI_OUT[15:0];
		else if (r < -PI_OUT) o = -PI_OUT[15:0];
		else o = r[15:0];
		return o;
	endfunction
endpackage

// ----- src/r2e_cell.sv -----
`timescale 1ns / 1ps
module r2e_cell import r2e_pkg::*; #(
	parameter int I = 0,
	parameter int L = 1,
	parameter int TW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vi,
	input  logic signed [W-1:0] xi [L],
	input  logic signed [W-1:0] yi [L],
	input  logic signed [ZW-1:0] zi [L],
	input  logic [TW-1:0] ti,
	output logic vo_s1,
	output logic signed [W-1:0] xo_s1 [L],
	output logic signed [W-1:0] yo_s1 [L],
	output logic signed [ZW-1:0] zo_s1 [L],
	output logic [TW-1:0] to_s1
);
	logic signed [W-1:0] xn [L];
	logic signed [W-1:0] yn [L];
	logic signed [ZW-1:0] zn [L];

	// One rotation step per lane: drive y toward zero.
	always_comb begin
		for (int l = 0; l < L; l++) begin
			if (!yi[l][W-1]) begin
				xn[l] = xi[l] + (yi[l] >>> I);
				yn[l] = yi[l] - (xi[l] >>> I);
				zn[l] = zi[l] + atan_fine(I);
			end else begin
				xn[l] = xi[l] - (yi[l] >>> I);
				yn[l] = yi[l] + (xi[l] >>> I);
				zn[l] = zi[l] - atan_fine(I);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_s1 <= 1'b0;
		end else if (en) begin
			vo_s1 <= vi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xo_s1 <= xn;
			yo_s1 <= yn;
			zo_s1 <= zn;
			to_s1 <= ti;
		end
	end
endmodule

// ----- src/r2e_chain.sv -----
`timescale 1ns / 1ps
module r2e_chain import r2e_pkg::*; #(
	parameter int N = STEPS_DEF,
	parameter int L = 1,
	parameter int TW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vi,
	input  logic signed [W-1:0] xi [L],
	input  logic signed [W-1:0] yi [L],
	input  logic signed [ZW-1:0] zi [L],
	input  logic [TW-1:0] ti,
	output logic vo,
	output logic signed [W-1:0] xo [L],
	output logic signed [W-1:0] yo [L],
	output logic signed [ZW-1:0] zo [L],
	output logic [TW-1:0] to
);
	logic v_w [N+1];
	logic signed [W-1:0] x_w [N+1][L];
	logic signed [W-1:0] y_w [N+1][L];
	logic signed [ZW-1:0] z_w [N+1][L];
	logic [TW-1:0] t_w [N+1];

	assign v_w[0] = vi;
	assign x_w[0] = xi;
	assign y_w[0] = yi;
	assign z_w[0] = zi;
	assign t_w[0] = ti;

	for (genvar k = 0; k < N; k++) begin : g_cell
		r2e_cell #(.I(k), .L(L), .TW(TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vi(v_w[k]), .xi(x_w[k]), .yi(y_w[k]), .zi(z_w[k]), .ti(t_w[k]),
			.vo_s1(v_w[k+1]), .xo_s1(x_w[k+1]), .yo_s1(y_w[k+1]),
			.zo_s1(z_w[k+1]), .to_s1(t_w[k+1])
		);
	end

	assign vo = v_w[N];
	assign xo = x_w[N];
	assign yo = y_w[N];
	assign zo = z_w[N];
	assign to = t_w[N];
endmodule

// ----- src/rotation_matrix_to_euler.sv -----
`timescale 1ns / 1ps
// Throughput: one matrix per cycle; two rows of CORDIC cells (magnitude, yaw
// and both roll candidates side by side, then pitch on the finished sy) run
// as one pipeline that holds as a whole while the output beat is not taken.
// Reset: arst_n clears all valid bits and sets singular_threshold to 1.
module rotation_matrix_to_euler import r2e_pkg::*; #(
	parameter int CORDIC_STEPS = STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// m00, m10, m11, m12, m20, m21, m22, 16 bits each from bit 0 up
	input  logic [111:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// roll_angle, pitch_angle, yaw_angle, 16 bits each from bit 0 up
	output logic [47:0] m_tdata,
	// is_singular
	output logic [0:0] m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [14:0] cfg_data
);
	localparam int T1 = 19;
	localparam int T2 = 34;

	logic [14:0] thr_q;
	logic en;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Advance everything when the output register is free or drained.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Unpack and prepare the four first-row lanes.
	logic signed [W-1:0] m [7];
	lane_t yaw_p, rn_p, rs_p;
	logic signed [W-1:0] x1 [4];
	logic signed [W-1:0] y1 [4];
	logic signed [ZW-1:0] z1 [4];
	logic [T1-1:0] t1;

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			m[k] = W'($signed(s_tdata[16*k +: 16]));
		end
		yaw_p = prep_atan(m[1], m[0]);
		rn_p = prep_atan(m[5], m[6]);
		rs_p = prep_atan(-m[3], m[2]);
		// magnitude lane: |m00| is never negative, no folding needed
		x1[0] = (m[0][W-1] ? -m[0] : m[0]) <<< PRE_SHIFT;
		y1[0] = m[1] <<< PRE_SHIFT;
		z1[0] = '0;
		x1[1] = yaw_p.x; y1[1] = yaw_p.y; z1[1] = yaw_p.z;
		x1[2] = rn_p.x;  y1[2] = rn_p.y;  z1[2] = rn_p.z;
		x1[3] = rs_p.x;  y1[3] = rs_p.y;  z1[3] = rs_p.z;
		t1 = {rs_p.zero, rn_p.zero, yaw_p.zero, s_tdata[64 +: 16]};
	end

	logic v1o;
	logic signed [W-1:0] x1o [4];
	logic signed [W-1:0] y1o [4];
	logic signed [ZW-1:0] z1o [4];
	logic [T1-1:0] t1o;

	r2e_chain #(.N(CORDIC_STEPS), .L(4), .TW(T1)) u_row1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vi(s_tvalid), .xi(x1), .yi(y1), .zi(z1), .ti(t1),
		.vo(v1o), .xo(x1o), .yo(y1o), .zo(z1o), .to(t1o)
	);

	// Stage p1: scale the magnitude by 1/K, finish the three angles.
	logic v_p1;
	logic signed [W+16:0] prod_p1;
	logic signed [15:0] yaw_p1, rn_p1, rs_p1;
	logic [15:0] m20_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else if (en) begin
			v_p1 <= v1o;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p1 <= (W+17)'(x1o[0]) * $signed({1'b0, INV_GAIN});
			yaw_p1 <= post_angle(z1o[1], t1o[16]);
			rn_p1 <= post_angle(z1o[2], t1o[17]);
			rs_p1 <= post_angle(z1o[3], t1o[18]);
			m20_p1 <= t1o[15:0];
		end
	end

	// Stage p2: sy, singular test, select roll and yaw.
	logic signed [W+16:0] sy_full;
	logic [16:0] sy_c;
	logic sing_c;
	logic v_p2;
	logic [16:0] sy_p2;
	logic [15:0] m20_p2, roll_p2, yaw_p2;
	logic sing_p2;

	always_comb begin
		sy_full = (prod_p1 + (W+17)'(64'sd8388608)) >>> 24;
		// drop a negative magnitude to zero
		sy_c = sy_full[W+16] ? '0 : sy_full[16:0];
		sing_c = sy_c < {2'b00, thr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sy_p2 <= sy_c;
			m20_p2 <= m20_p1;
			sing_p2 <= sing_c;
			roll_p2 <= sing_c ? rs_p1 : rn_p1;
			yaw_p2 <= sing_c ? 16'd0 : yaw_p1;
		end
	end

	// Second row: pitch = atan2(-m20, sy); sy is never negative.
	lane_t pit_p;
	logic signed [W-1:0] x2 [1];
	logic signed [W-1:0] y2 [1];
	logic signed [ZW-1:0] z2 [1];
	logic [T2-1:0] t2;

	always_comb begin
		pit_p = prep_atan(-W'($signed(m20_p2)), W'(sy_p2));
		x2[0] = pit_p.x;
		y2[0] = pit_p.y;
		z2[0] = pit_p.z;
		t2 = {pit_p.zero, sing_p2, yaw_p2, roll_p2};
	end

	logic v2o;
	logic signed [W-1:0] x2o [1];
	logic signed [W-1:0] y2o [1];
	logic signed [ZW-1:0] z2o [1];
	logic [T2-1:0] t2o;

	r2e_chain #(.N(CORDIC_STEPS), .L(1), .TW(T2)) u_row2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vi(v_p2), .xi(x2), .yi(y2), .zi(z2), .ti(t2),
		.vo(v2o), .xo(x2o), .yo(y2o), .zo(z2o), .to(t2o)
	);

	// Output register: hold the beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v2o;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {t2o[31:16], post_angle(z2o[0], t2o[33]), t2o[15:0]};
			m_tuser <= t2o[32];
		end
	end
endmodule
